// File: rtl/core/bbpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Biquadratic patch tessellator package
// Shared types, constants and helper functions of the tessellator core.
// ----------------------------------------------------------------------------
package bbpt_pkg;

	localparam int LEVEL_W   = 3;
	localparam int MAX_LEVEL = 7;
	localparam logic [LEVEL_W-1:0] DEFAULT_LEVEL = 3'd4;
	localparam logic [LEVEL_W-1:0] MIN_LEVEL     = 3'd1;

	localparam int NUM_CRD   = 7;
	localparam int NUM_NRM   = 3;
	localparam int NUM_BYTES = 4;
	localparam int NUM_ROWS  = 12;
	localparam int ROW_AW    = 4;

	localparam logic [ROW_AW-1:0] LAST_CTRL_ROW = 4'd8;
	localparam logic [ROW_AW-1:0] COL_BASE      = 4'd9;

	localparam logic [3:0] COMP_NRM  = 4'd7;
	localparam logic [3:0] COMP_RGB  = 4'd10;
	localparam logic [3:0] COMP_LAST = 4'd13;

	localparam int CRD_X  = 0;
	localparam int CRD_Y  = 1;
	localparam int CRD_Z  = 2;
	localparam int CRD_TS = 3;
	localparam int CRD_TT = 4;
	localparam int CRD_LS = 5;
	localparam int CRD_LT = 6;

	localparam int BYTE_R = 0;
	localparam int BYTE_G = 1;
	localparam int BYTE_B = 2;
	localparam int BYTE_A = 3;

	localparam int W_W       = 6;
	localparam int ACC_W     = 40;
	localparam int MAG_W     = 38;
	localparam int DIV_N_W   = 41;
	localparam int DIV_D_W   = 27;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);
	localparam int NRM_SHIFT = 25;
	localparam int SUMSQ_W   = 32;
	localparam int SQRT_PAD  = 20;
	localparam int SQRT_IN_W = SUMSQ_W + SQRT_PAD;
	localparam int LEN_W     = SQRT_IN_W / 2;
	localparam int SQRT_CNT_W = $clog2(LEN_W + 1);

	localparam logic [1:0] TERM_A = 2'd0;
	localparam logic [1:0] TERM_B = 2'd1;
	localparam logic [1:0] TERM_C = 2'd2;

	typedef enum logic [1:0] {
		DIV_ROUND,
		DIV_FLOOR,
		DIV_NORM
	} div_mode_t;

	typedef enum logic {
		WSEL_LOAD,
		WSEL_EVAL
	} wsel_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] tex_s;
		logic signed [31:0] tex_t;
		logic signed [31:0] light_s;
		logic signed [31:0] light_t;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic [31:0]        color_rgba;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] out_tex_s;
		logic signed [31:0] out_tex_t;
		logic signed [31:0] out_light_s;
		logic signed [31:0] out_light_t;
		logic signed [15:0] out_norm_x;
		logic signed [15:0] out_norm_y;
		logic signed [15:0] out_norm_z;
		logic [31:0]        color_argb;
		logic               last_vertex;
	} out_item_t;

	typedef struct packed {
		logic [NUM_CRD-1:0][31:0]  crd;
		logic [NUM_NRM-1:0][15:0]  nrm;
		logic [NUM_BYTES-1:0][7:0] rgba;
	} vtx_t;

	typedef struct packed {
		logic              mem_we;
		wsel_t             mem_wsel;
		logic [ROW_AW-1:0] mem_waddr;
		logic              mem_re;
		logic [ROW_AW-1:0] mem_raddr;
		logic              acc_en;
		logic              acc_clr;
		logic [W_W-1:0]    weight;
		logic [W_W-1:0]    den;
		logic [3:0]        comp;
		logic [1:0]        nidx;
		logic              div_start;
		div_mode_t         div_mode;
		logic              eval_we;
		logic              sq_en;
		logic              sq_clr;
		logic              sqrt_start;
		logic              emit;
		logic              last;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic s_zero;
	} dp_stat_t;

	function automatic logic [W_W-1:0] bern_weight(input logic [LEVEL_W-1:0] lvl,
		input logic [LEVEL_W-1:0] t, input logic [1:0] k);
		logic [W_W-1:0] a;
		logic [W_W-1:0] b;
		logic [W_W-1:0] w;
		a = W_W'(lvl - t);
		b = W_W'(t);
		case (k)
			TERM_A: w = a * a;
			TERM_B: w = (a * b) << 1;
			TERM_C: w = b * b;
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic signed [31:0] comp_get(input vtx_t v, input logic [3:0] f);
		logic [3:0] off;
		logic signed [31:0] r;
		if (f < COMP_NRM) begin
			r = v.crd[f[2:0]];
		end else if (f < COMP_RGB) begin
			off = f - COMP_NRM;
			r = 32'($signed(v.nrm[off[1:0]]));
		end else begin
			off = f - COMP_RGB;
			r = {24'b0, v.rgba[off[1:0]]};
		end
		return r;
	endfunction

	function automatic vtx_t comp_set(input vtx_t v, input logic [3:0] f,
		input logic [31:0] val);
		logic [3:0] off;
		vtx_t r;
		r = v;
		if (f < COMP_NRM) begin
			r.crd[f[2:0]] = val;
		end else if (f < COMP_RGB) begin
			off = f - COMP_NRM;
			r.nrm[off[1:0]] = val[15:0];
		end else begin
			off = f - COMP_RGB;
			r.rgba[off[1:0]] = val[7:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/biquadratic_bezier_patch_tessellator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Biquadratic Bezier patch tessellator core
// Loads nine control vertices and emits an (L+1) x (L+1) vertex grid.
// ----------------------------------------------------------------------------
// Control vertices are taken one per cycle while busy is low. The ninth one
// starts tessellation: busy rises and the grid comes out row by row, one
// vertex per result_valid pulse of a single cycle, with last_vertex on the
// final one; results cannot be held off. Each evaluated vertex (three column
// points per grid row plus L+1 grid vertices, so (L+1)(L+4) per patch) goes
// through the serial divider, which produces each of its fourteen components
// at one quotient bit per cycle, then through the normal renormalization
// (square root and three more divides) unless its normal sums to zero.
// ----------------------------------------------------------------------------
module biquadratic_bezier_patch_tessellator_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire bbpt_pkg::in_item_t           vertex,
	input  wire logic                         cfg_we,
	input  wire logic [bbpt_pkg::LEVEL_W-1:0] cfg_wdata,
	output logic                              result_valid,
	output bbpt_pkg::out_item_t               result
);
	import bbpt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bbpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.busy      (busy),
		.cmd       (cmd),
		.stat      (stat)
	);

	bbpt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex       (vertex),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
`default_nettype wire

// File: rtl/core/bbpt_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bbpt_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [bbpt_pkg::DIV_N_W-1:0] dividend,
	input  wire logic [bbpt_pkg::DIV_D_W-1:0] divisor,
	output logic [bbpt_pkg::DIV_N_W-1:0]      quotient,
	output logic                              done
);
	import bbpt_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_D_W-1:0]   dvs_q;
	logic [DIV_D_W:0]     shifted;
	logic [DIV_D_W:0]     diff;
	logic                 ge;

	assign shifted = {rem_q, quo_q[DIV_N_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DIV_CNT_W'(DIV_N_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule
`default_nettype wire

// File: rtl/core/bbpt_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial square root
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module bbpt_sqrt (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [bbpt_pkg::SQRT_IN_W-1:0] radicand,
	output logic [bbpt_pkg::LEN_W-1:0]          root,
	output logic                                done
);
	import bbpt_pkg::*;

	localparam logic [SQRT_IN_W-1:0] BIT0 = SQRT_IN_W'(1) << (SQRT_IN_W - 2);

	logic [SQRT_CNT_W-1:0] cnt_q;
	logic                  done_q;
	logic [SQRT_IN_W-1:0]  rem_q;
	logic [SQRT_IN_W-1:0]  res_q;
	logic [SQRT_IN_W-1:0]  bit_q;
	logic [SQRT_IN_W:0]    trial;
	logic                  ge;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign ge    = {1'b0, rem_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= SQRT_CNT_W'(LEN_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SQRT_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= BIT0;
		end else if (cnt_q != '0) begin
			if (ge) begin
				rem_q <= rem_q - trial[SQRT_IN_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[LEN_W-1:0];
	assign done = done_q;

endmodule
`default_nettype wire

// File: rtl/core/bbpt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tessellator datapath
// Vertex store, weighted accumulator, normal length unit, shared divider
// and result register.
// ----------------------------------------------------------------------------
module bbpt_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bbpt_pkg::in_item_t  vertex,
	input  wire bbpt_pkg::dp_cmd_t   cmd,
	output bbpt_pkg::dp_stat_t       stat,
	output logic                     result_valid,
	output bbpt_pkg::out_item_t      result
);
	import bbpt_pkg::*;

	vtx_t mem [NUM_ROWS];
	vtx_t rd_q;
	vtx_t eval_q;
	vtx_t load_row;
	vtx_t wr_row;

	logic signed [31:0]      comp_val;
	logic signed [W_W+32:0]  prod;
	logic signed [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0]        acc_mag;
	logic signed [15:0]      nrm_sel;
	logic [15:0]             nrm_mag;
	logic signed [31:0]      sq_prod;
	logic [SUMSQ_W-1:0]      s_q;
	logic [LEN_W-1:0]        len;
	logic                    sqrt_done;
	logic [DIV_N_W-1:0]      div_n;
	logic [DIV_D_W-1:0]      div_d;
	logic [DIV_N_W-1:0]      quo;
	logic                    div_done;
	logic                    neg;
	logic [DIV_N_W-1:0]      sval;
	logic                    valid_q;
	out_item_t               out_q;

	always_comb begin
		load_row.crd[CRD_X]  = vertex.pos_x;
		load_row.crd[CRD_Y]  = vertex.pos_y;
		load_row.crd[CRD_Z]  = vertex.pos_z;
		load_row.crd[CRD_TS] = vertex.tex_s;
		load_row.crd[CRD_TT] = vertex.tex_t;
		load_row.crd[CRD_LS] = vertex.light_s;
		load_row.crd[CRD_LT] = vertex.light_t;
		load_row.nrm[0]      = vertex.norm_x;
		load_row.nrm[1]      = vertex.norm_y;
		load_row.nrm[2]      = vertex.norm_z;
		load_row.rgba        = vertex.color_rgba;
	end

	assign wr_row = (cmd.mem_wsel == WSEL_LOAD) ? load_row : eval_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[cmd.mem_waddr] <= wr_row;
		end
		if (cmd.mem_re) begin
			rd_q <= mem[cmd.mem_raddr];
		end
	end

	assign comp_val = comp_get(rd_q, cmd.comp);
	assign prod     = $signed({1'b0, cmd.weight}) * comp_val;
	assign acc_mag  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

	assign nrm_sel = eval_q.nrm[cmd.nidx];
	assign nrm_mag = nrm_sel[15] ? 16'(-nrm_sel) : 16'(nrm_sel);
	assign sq_prod = nrm_sel * nrm_sel;

	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			acc_q <= cmd.acc_clr ? ACC_W'(prod) : acc_q + ACC_W'(prod);
		end
		if (cmd.sq_en) begin
			s_q <= cmd.sq_clr ? SUMSQ_W'(sq_prod) : s_q + SUMSQ_W'(sq_prod);
		end
	end

	bbpt_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand ({s_q, SQRT_PAD'(0)}),
		.root     (len),
		.done     (sqrt_done)
	);

	always_comb begin
		case (cmd.div_mode)
			DIV_ROUND: begin
				div_n = (DIV_N_W'(acc_mag[MAG_W-1:0]) << 1) + DIV_N_W'(cmd.den);
				div_d = DIV_D_W'({cmd.den, 1'b0});
			end
			DIV_FLOOR: begin
				div_n = DIV_N_W'(acc_mag[MAG_W-1:0]);
				div_d = DIV_D_W'(cmd.den);
			end
			DIV_NORM: begin
				div_n = (DIV_N_W'(nrm_mag) << NRM_SHIFT) + DIV_N_W'(len);
				div_d = {len, 1'b0};
			end
			default: begin
				div_n = '0;
				div_d = '0;
			end
		endcase
	end

	bbpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.quotient (quo),
		.done     (div_done)
	);

	assign neg  = (cmd.div_mode == DIV_NORM) ? nrm_sel[15] : acc_q[ACC_W-1];
	assign sval = neg ? (DIV_N_W'(0) - quo) : quo;

	always_ff @(posedge clk) begin
		if (cmd.eval_we) begin
			if (cmd.div_mode == DIV_NORM) begin
				eval_q.nrm[cmd.nidx] <= sval[15:0];
			end else begin
				eval_q <= comp_set(eval_q, cmd.comp, sval[31:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.out_x       <= eval_q.crd[CRD_X];
			out_q.out_y       <= eval_q.crd[CRD_Y];
			out_q.out_z       <= eval_q.crd[CRD_Z];
			out_q.out_tex_s   <= eval_q.crd[CRD_TS];
			out_q.out_tex_t   <= eval_q.crd[CRD_TT];
			out_q.out_light_s <= eval_q.crd[CRD_LS];
			out_q.out_light_t <= eval_q.crd[CRD_LT];
			out_q.out_norm_x  <= eval_q.nrm[0];
			out_q.out_norm_y  <= eval_q.nrm[1];
			out_q.out_norm_z  <= eval_q.nrm[2];
			out_q.color_argb  <= {eval_q.rgba[BYTE_A], eval_q.rgba[BYTE_R],
				eval_q.rgba[BYTE_G], eval_q.rgba[BYTE_B]};
			out_q.last_vertex <= cmd.last;
		end
	end

	assign stat.div_done  = div_done;
	assign stat.sqrt_done = sqrt_done;
	assign stat.s_zero    = (s_q == '0);
	assign result_valid   = valid_q;
	assign result         = out_q;

endmodule
`default_nettype wire

// File: rtl/core/bbpt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tessellator controller
// Level register, load counter and the sequencer that walks grid rows,
// column evaluations, components and normal renormalization.
// ----------------------------------------------------------------------------
module bbpt_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic                         cfg_we,
	input  wire logic [bbpt_pkg::LEVEL_W-1:0] cfg_wdata,
	output logic                              busy,
	output bbpt_pkg::dp_cmd_t                 cmd,
	input  wire bbpt_pkg::dp_stat_t           stat
);
	import bbpt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_MAC,
		S_DSTART,
		S_DWAIT,
		S_SQ,
		S_SQCHK,
		S_SQRTW,
		S_NDSTART,
		S_NDWAIT,
		S_FIN
	} state_t;

	typedef enum logic {
		P_COL,
		P_GRID
	} pass_t;

	state_t             state_q;
	pass_t              pass_q;
	logic               busy_q;
	logic [LEVEL_W-1:0] cfg_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic [ROW_AW-1:0]  load_q;
	logic [3:0]         f_q;
	logic [1:0]         k_q;
	logic [1:0]         c_q;
	logic [1:0]         n_q;
	logic [LEVEL_W-1:0] i_q;
	logic [LEVEL_W-1:0] j_q;
	logic [LEVEL_W-1:0] t_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= DEFAULT_LEVEL;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= P_COL;
			busy_q  <= 1'b0;
			lvl_q   <= MIN_LEVEL;
			load_q  <= '0;
			f_q     <= '0;
			k_q     <= '0;
			c_q     <= '0;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (load_q == LAST_CTRL_ROW) begin
							load_q  <= '0;
							lvl_q   <= (cfg_q == '0) ? MIN_LEVEL : cfg_q;
							pass_q  <= P_COL;
							i_q     <= '0;
							j_q     <= '0;
							c_q     <= '0;
							f_q     <= '0;
							k_q     <= '0;
							busy_q  <= 1'b1;
							state_q <= S_RD;
						end else begin
							load_q <= load_q + 1'b1;
						end
					end
				end
				S_RD: begin
					state_q <= S_MAC;
				end
				S_MAC: begin
					if (k_q == TERM_C) begin
						k_q     <= '0;
						state_q <= S_DSTART;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_DSTART: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (stat.div_done) begin
						if (f_q == COMP_LAST) begin
							f_q     <= '0;
							n_q     <= '0;
							state_q <= S_SQ;
						end else begin
							f_q     <= f_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_SQ: begin
					if (n_q == 2'(NUM_NRM - 1)) begin
						n_q     <= '0;
						state_q <= S_SQCHK;
					end else begin
						n_q <= n_q + 1'b1;
					end
				end
				S_SQCHK: begin
					state_q <= stat.s_zero ? S_FIN : S_SQRTW;
				end
				S_SQRTW: begin
					if (stat.sqrt_done) begin
						state_q <= S_NDSTART;
					end
				end
				S_NDSTART: begin
					state_q <= S_NDWAIT;
				end
				S_NDWAIT: begin
					if (stat.div_done) begin
						if (n_q == 2'(NUM_NRM - 1)) begin
							n_q     <= '0;
							state_q <= S_FIN;
						end else begin
							n_q     <= n_q + 1'b1;
							state_q <= S_NDSTART;
						end
					end
				end
				S_FIN: begin
					state_q <= S_RD;
					if (pass_q == P_COL) begin
						if (c_q == 2'd2) begin
							pass_q <= P_GRID;
							j_q    <= '0;
						end else begin
							c_q <= c_q + 1'b1;
						end
					end else if (j_q == lvl_q) begin
						if (i_q == lvl_q) begin
							busy_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							i_q    <= i_q + 1'b1;
							c_q    <= '0;
							pass_q <= P_COL;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign t_sel = (pass_q == P_COL) ? i_q : j_q;

	always_comb begin
		cmd            = '0;
		cmd.mem_wsel   = WSEL_EVAL;
		cmd.mem_waddr  = COL_BASE + ROW_AW'(c_q);
		cmd.mem_raddr  = (pass_q == P_COL) ?
			(ROW_AW'(c_q) + (ROW_AW'(k_q) << 1) + ROW_AW'(k_q)) :
			(COL_BASE + ROW_AW'(k_q));
		cmd.weight     = bern_weight(lvl_q, t_sel, k_q);
		cmd.den        = W_W'(lvl_q) * W_W'(lvl_q);
		cmd.comp       = f_q;
		cmd.nidx       = n_q;
		cmd.acc_clr    = (k_q == TERM_A);
		cmd.sq_clr     = (n_q == '0);
		cmd.last       = (j_q == lvl_q) && (i_q == lvl_q);
		if ((state_q == S_NDSTART) || (state_q == S_NDWAIT)) begin
			cmd.div_mode = DIV_NORM;
		end else if (f_q < COMP_RGB) begin
			cmd.div_mode = DIV_ROUND;
		end else begin
			cmd.div_mode = DIV_FLOOR;
		end
		unique case (state_q)
			S_IDLE: begin
				cmd.mem_we    = start;
				cmd.mem_wsel  = WSEL_LOAD;
				cmd.mem_waddr = load_q;
			end
			S_RD:      cmd.mem_re     = 1'b1;
			S_MAC:     cmd.acc_en     = 1'b1;
			S_DSTART:  cmd.div_start  = 1'b1;
			S_DWAIT:   cmd.eval_we    = stat.div_done;
			S_SQ:      cmd.sq_en      = 1'b1;
			S_SQCHK:   cmd.sqrt_start = !stat.s_zero;
			S_SQRTW:   cmd.sqrt_start = 1'b0;
			S_NDSTART: cmd.div_start  = 1'b1;
			S_NDWAIT:  cmd.eval_we    = stat.div_done;
			S_FIN: begin
				cmd.mem_we = (pass_q == P_COL);
				cmd.emit   = (pass_q == P_GRID);
			end
			default: cmd.mem_re = 1'b0;
		endcase
	end

	assign busy = busy_q;

endmodule
`default_nettype wire

// File: rtl/core/bbpt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tessellator port checker
// Properties on the core's ports, bound to the top level.
// ----------------------------------------------------------------------------
module bbpt_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic                result_valid,
	input wire bbpt_pkg::out_item_t result
);
	import bbpt_pkg::*;

	a_beat_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result beats back to back");

	a_busy_mid_grid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_vertex |-> busy)
		else $error("busy low before the final beat");

	a_idle_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_vertex |-> !busy)
		else $error("busy still high on the final beat");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted beat");

endmodule

bind biquadratic_bezier_patch_tessellator_core bbpt_checker u_bbpt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
`default_nettype wire

// File: verif/biquadratic_bezier_patch_tessellator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Patch tessellator core testbench
// Loads 3x3 control vertex patches under changing subdivision levels and
// checks every emitted grid vertex against a bit-true tessellation predictor.
// ----------------------------------------------------------------------------
module biquadratic_bezier_patch_tessellator_core_tb;
	import bbpt_pkg::*;

	localparam int GAP_MAX      = 14;
	localparam int STALL_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 64;
	localparam int RAND_PATCHES = 26;
	localparam int NUM_DIRECTED = 18;

	typedef struct {
		longint crd[NUM_CRD];
		longint nrm[NUM_NRM];
		logic [31:0] rgba;
	} cvert_t;

	typedef struct {
		in_item_t           v;
		bit                 wr;
		logic [LEVEL_W-1:0] lvl;
		bit                 zero_grid;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	in_item_t            vertex;
	logic                cfg_we;
	logic [LEVEL_W-1:0]  cfg_wdata;
	logic                result_valid;
	out_item_t           result;

	cvert_t              ctrl_pts[9];
	int                  load_slot;
	logic [LEVEL_W-1:0]  level_reg;
	out_item_t           grid_q[$];
	int                  errors;
	int                  stall_cnt;
	stim_row_t           dir_tab[NUM_DIRECTED];

	biquadratic_bezier_patch_tessellator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.vertex(vertex),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.result_valid(result_valid),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint div_nearest(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag * 2 + den) / (den * 2);
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint int_sqrt(longint v);
		longint rem;
		longint res;
		longint b;
		rem = v;
		res = 0;
		b = 64'sh4000_0000_0000_0000;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >>> 1) + b;
			end else begin
				res = res >>> 1;
			end
			b = b >>> 2;
		end
		return res;
	endfunction

	function automatic cvert_t bezier_eval(cvert_t p0, cvert_t p1, cvert_t p2, int k, int lv);
		cvert_t o;
		longint wa;
		longint wb;
		longint wc;
		longint den;
		longint s;
		longint len;
		wa = (lv - k) * (lv - k);
		wb = 2 * (lv - k) * k;
		wc = k * k;
		den = lv * lv;
		for (int f = 0; f < NUM_CRD; f++)
			o.crd[f] = div_nearest(wa * p0.crd[f] + wb * p1.crd[f] + wc * p2.crd[f], den);
		for (int f = 0; f < NUM_NRM; f++)
			o.nrm[f] = div_nearest(wa * p0.nrm[f] + wb * p1.nrm[f] + wc * p2.nrm[f], den);
		s = o.nrm[0] * o.nrm[0] + o.nrm[1] * o.nrm[1] + o.nrm[2] * o.nrm[2];
		if (s == 0) begin
			for (int f = 0; f < NUM_NRM; f++) o.nrm[f] = 0;
		end else begin
			len = int_sqrt(s << 20);
			for (int f = 0; f < NUM_NRM; f++)
				o.nrm[f] = div_nearest(o.nrm[f] * 16777216, len);
		end
		for (int f = 0; f < NUM_BYTES; f++) begin
			s = wa * p0.rgba[f*8 +: 8] + wb * p1.rgba[f*8 +: 8] + wc * p2.rgba[f*8 +: 8];
			o.rgba[f*8 +: 8] = 8'(s / den);
		end
		return o;
	endfunction

	// Store one control vertex; on the ninth, queue the whole grid.
	task automatic load_control(in_item_t v, bit zero_grid);
		cvert_t cols[3];
		cvert_t g;
		out_item_t r;
		int lv;
		ctrl_pts[load_slot].crd[CRD_X]  = v.pos_x;
		ctrl_pts[load_slot].crd[CRD_Y]  = v.pos_y;
		ctrl_pts[load_slot].crd[CRD_Z]  = v.pos_z;
		ctrl_pts[load_slot].crd[CRD_TS] = v.tex_s;
		ctrl_pts[load_slot].crd[CRD_TT] = v.tex_t;
		ctrl_pts[load_slot].crd[CRD_LS] = v.light_s;
		ctrl_pts[load_slot].crd[CRD_LT] = v.light_t;
		ctrl_pts[load_slot].nrm[0] = v.norm_x;
		ctrl_pts[load_slot].nrm[1] = v.norm_y;
		ctrl_pts[load_slot].nrm[2] = v.norm_z;
		ctrl_pts[load_slot].rgba = v.color_rgba;
		if (load_slot < 8) begin
			load_slot++;
			return;
		end
		load_slot = 0;
		lv = (level_reg < MIN_LEVEL) ? MIN_LEVEL : level_reg;
		for (int i = 0; i <= lv; i++) begin
			for (int c = 0; c < 3; c++)
				cols[c] = bezier_eval(ctrl_pts[c], ctrl_pts[c+3], ctrl_pts[c+6], i, lv);
			for (int j = 0; j <= lv; j++) begin
				g = bezier_eval(cols[0], cols[1], cols[2], j, lv);
				r.out_x       = g.crd[CRD_X];
				r.out_y       = g.crd[CRD_Y];
				r.out_z       = g.crd[CRD_Z];
				r.out_tex_s   = g.crd[CRD_TS];
				r.out_tex_t   = g.crd[CRD_TT];
				r.out_light_s = g.crd[CRD_LS];
				r.out_light_t = g.crd[CRD_LT];
				r.out_norm_x  = g.nrm[0];
				r.out_norm_y  = g.nrm[1];
				r.out_norm_z  = g.nrm[2];
				r.color_argb  = {g.rgba[31:24], g.rgba[7:0], g.rgba[15:8], g.rgba[23:16]};
				r.last_vertex = (i == lv && j == lv);
				if (zero_grid) begin
					r = '0;
					r.last_vertex = (i == lv && j == lv);
				end
				grid_q = {grid_q, r};
			end
		end
	endtask

	task automatic report(string field, logic [31:0] got, logic [31:0] exp_val);
		$display("%0t mismatch %s: got %h exp %h", $realtime, field, got, exp_val);
		errors++;
	endtask

	always @(posedge clk) begin
		out_item_t e;
		if (result_valid) begin
			if (grid_q.size() == 0) begin
				report("unexpected beat", result.out_x, 32'h0);
			end else begin
				e = grid_q.pop_front();
				if (result.out_x !== e.out_x) report("out_x", result.out_x, e.out_x);
				if (result.out_y !== e.out_y) report("out_y", result.out_y, e.out_y);
				if (result.out_z !== e.out_z) report("out_z", result.out_z, e.out_z);
				if (result.out_tex_s !== e.out_tex_s)
					report("out_tex_s", result.out_tex_s, e.out_tex_s);
				if (result.out_tex_t !== e.out_tex_t)
					report("out_tex_t", result.out_tex_t, e.out_tex_t);
				if (result.out_light_s !== e.out_light_s)
					report("out_light_s", result.out_light_s, e.out_light_s);
				if (result.out_light_t !== e.out_light_t)
					report("out_light_t", result.out_light_t, e.out_light_t);
				if (result.out_norm_x !== e.out_norm_x)
					report("out_norm_x", 32'(result.out_norm_x), 32'(e.out_norm_x));
				if (result.out_norm_y !== e.out_norm_y)
					report("out_norm_y", 32'(result.out_norm_y), 32'(e.out_norm_y));
				if (result.out_norm_z !== e.out_norm_z)
					report("out_norm_z", 32'(result.out_norm_z), 32'(e.out_norm_z));
				if (result.color_argb !== e.color_argb)
					report("color_argb", result.color_argb, e.color_argb);
				if (result.last_vertex !== e.last_vertex)
					report("last_vertex", 32'(result.last_vertex), 32'(e.last_vertex));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || result_valid || (start && !busy)) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic send_vertex(in_item_t v, bit zero_grid);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start  <= 1'b1;
		vertex <= v;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		load_control(v, zero_grid);
	endtask

	task automatic write_level(logic [LEVEL_W-1:0] lvl);
		@(negedge clk);
		start <= 1'b0;
		if (load_slot == 0) begin
			wait (grid_q.size() == 0);
			@(negedge clk);
			while (busy) @(negedge clk);
		end
		cfg_we    <= 1'b1;
		cfg_wdata <= lvl;
		@(negedge clk);
		cfg_we    <= 1'b0;
		level_reg = lvl;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_half(bit zero);
		if (zero) return '0;
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($signed($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_item_t rand_vertex();
		in_item_t v;
		bit zn;
		zn = ($urandom_range(0, 7) == 0);
		v.pos_x   = rand_word();
		v.pos_y   = rand_word();
		v.pos_z   = rand_word();
		v.tex_s   = rand_word();
		v.tex_t   = rand_word();
		v.light_s = rand_word();
		v.light_t = rand_word();
		v.norm_x  = rand_half(zn);
		v.norm_y  = rand_half(zn);
		v.norm_z  = rand_half(zn);
		v.color_rgba = ($urandom_range(0, 4) == 0) ? 32'hffff_ffff : $urandom;
		return v;
	endfunction

	function automatic logic [LEVEL_W-1:0] rand_level();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70) return LEVEL_W'($urandom_range(0, 2));
		if (p < 95) return LEVEL_W'($urandom_range(3, 4));
		return LEVEL_W'($urandom_range(5, MAX_LEVEL));
	endfunction

	initial begin
		in_item_t v;
		errors    = 0;
		load_slot = 0;
		level_reg = DEFAULT_LEVEL;
		start     = 1'b0;
		vertex    = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		arst_n    = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero patch at level zero (acts as one): all outputs zero
		for (int k = 0; k < 9; k++) begin
			dir_tab[k] = '{v: '0, wr: 1'b0, lvl: '0, zero_grid: 1'b1};
		end
		dir_tab[0].wr = 1'b1;
		// extremes patch; level changes during load, the last one wins
		for (int k = 0; k < 9; k++) begin
			v = '0;
			v.pos_x   = k[0] ? 32'h8000_0000 : 32'h7fff_ffff;
			v.pos_y   = k[0] ? 32'h7fff_ffff : 32'h8000_0000;
			v.pos_z   = 32'hffff_ffff;
			v.tex_s   = k[1] ? 32'h8000_0000 : 32'h7fff_ffff;
			v.tex_t   = 32'h0001_0000;
			v.light_s = k[0] ? 32'h7fff_ffff : '0;
			v.light_t = 32'h8000_0000;
			case (k % 3)
				0: begin v.norm_x = 16'h7fff; v.norm_y = 16'h7fff; v.norm_z = 16'h7fff; end
				1: begin v.norm_x = 16'h8000; v.norm_y = 16'h8000; v.norm_z = 16'h8000; end
				default: begin v.norm_x = '0; v.norm_y = '0; v.norm_z = '0; end
			endcase
			v.color_rgba = k[0] ? 32'hffff_ffff : 32'h0;
			dir_tab[9 + k] = '{v: v, wr: 1'b0, lvl: '0, zero_grid: 1'b0};
		end
		dir_tab[9].wr  = 1'b1;
		dir_tab[9].lvl = 3'd3;
		dir_tab[13].wr  = 1'b1;
		dir_tab[13].lvl = 3'(MAX_LEVEL);

		for (int r = 0; r < NUM_DIRECTED; r++) begin
			if (dir_tab[r].wr) write_level(dir_tab[r].lvl);
			send_vertex(dir_tab[r].v, dir_tab[r].zero_grid);
		end

		for (int p = 0; p < RAND_PATCHES; p++) begin
			for (int k = 0; k < 9; k++) begin
				if ((k == 0 && $urandom_range(0, 1) == 0) || $urandom_range(0, 29) == 0)
					write_level(rand_level());
				send_vertex(rand_vertex(), 1'b0);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		wait (grid_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
